/* sv/go_to_goal_pose_controller_defines.svh */
// ---------------------------------------------------------------------------
// go_to_goal_pose_controller_defines
// Assertion macros shared by the controller's checks.
// ---------------------------------------------------------------------------
`ifndef GO_TO_GOAL_POSE_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_POSE_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GTG_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtg: same-cycle check failed");

// next-cycle implication, disabled in reset
`define GTG_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtg: next-cycle check failed");

`endif

/* sv/gtg_pkg.sv */
// ---------------------------------------------------------------------------
// gtg_pkg
// Types, codes and constants of the go-to-goal pose controller.
// ---------------------------------------------------------------------------
package gtg_pkg;

    // angle datapath width (signed Q6.16 radians, headroom for CORDIC sums)
    localparam int ANG_W = 22;
    localparam int HDG_W = 19;
    localparam int POS_W = 32;
    localparam int CFG_W = 31;

    localparam logic signed [ANG_W-1:0] Q_PI      = ANG_W'(205887);
    localparam logic signed [ANG_W-1:0] Q_HALF_PI = ANG_W'(102944);
    localparam logic signed [ANG_W-1:0] Q_TWO_PI  = ANG_W'(411774);
    localparam logic [15:0]             INV_GAIN  = 16'd39797;

    // event kinds on tuser
    localparam logic [1:0] CMD_POSE     = 2'd0;
    localparam logic [1:0] CMD_GOAL     = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MAX_LIN  = 3'd0;
    localparam logic [2:0] REG_MAX_ANG  = 3'd1;
    localparam logic [2:0] REG_LIN_GAIN = 3'd2;
    localparam logic [2:0] REG_ANG_GAIN = 3'd3;
    localparam logic [2:0] REG_DIST_TOL = 3'd4;
    localparam logic [2:0] REG_YAW_TOL  = 3'd5;
    localparam logic [2:0] REG_REALIGN  = 3'd6;

    typedef enum logic [1:0] {
        OP_POSE,
        OP_GOAL,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ROTATE = 3'd1,
        PH_MOVE   = 3'd2,
        PH_FINAL  = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } cmode_t;

    typedef enum logic {
        C_IDLE,
        C_RUN
    } cstate_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PREP,
        B_VEC,
        B_MAG_HI,
        B_MAG_LO,
        B_DECIDE,
        B_COS,
        B_LIN_P1,
        B_LIN_P2,
        B_LIN_SUM,
        B_LIN_QLO,
        B_LIN_QHI,
        B_LIN_CLAMP,
        B_ANG_MUL,
        B_ANG_CLAMP,
        B_EMIT
    } bstate_t;

    typedef struct packed {
        op_t                 op;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [HDG_W-1:0]    hdg;
    } item_t;

    typedef struct packed {
        logic   start;
        cmode_t mode;
    } cord_req_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_lin;
        logic [CFG_W-1:0] max_ang;
        logic [CFG_W-1:0] lin_gain;
        logic [CFG_W-1:0] ang_gain;
        logic [CFG_W-1:0] dist_tol;
        logic [CFG_W-1:0] yaw_tol;
        logic [CFG_W-1:0] realign;
    } cfg_t;

    // atan(2^-i), Q0.16, rounded
    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // fold an angle into (-pi, pi]; one correction either way is enough here
    function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] r;
        r = a;
        if (r > Q_PI)
            r = r - Q_TWO_PI;
        else if (r <= -Q_PI)
            r = r + Q_TWO_PI;
        return r;
    endfunction

endpackage

/* sv/gtg_front.sv */
// ---------------------------------------------------------------------------
// gtg_front
// Takes requests off the input stream and classifies them by event kind.
// ---------------------------------------------------------------------------
module gtg_front
    import gtg_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        q_full,
    output logic        push,
    output item_t       push_item
);

    logic accept;
    logic known;
    op_t  op;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        unique case (s_tuser)
            CMD_POSE:
            begin
                op    = OP_POSE;
                known = 1'b1;
            end
            CMD_GOAL:
            begin
                op    = OP_GOAL;
                known = 1'b1;
            end
            CMD_TICK:
            begin
                op    = OP_TICK;
                known = 1'b1;
            end
            default:
            begin
                // reserved kind: taken and dropped
                op    = OP_TICK;
                known = 1'b0;
            end
        endcase
    end

    assign push          = accept && known;
    assign push_item.op  = op;
    assign push_item.x   = s_tdata[31:0];
    assign push_item.y   = s_tdata[63:32];
    assign push_item.hdg = s_tdata[82:64];

endmodule

/* sv/gtg_queue.sv */
// ---------------------------------------------------------------------------
// gtg_queue
// Two-entry request queue between front and back.
// ---------------------------------------------------------------------------
module gtg_queue
    import gtg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/gtg_cordic.sv */
// ---------------------------------------------------------------------------
// gtg_cordic
// Shared iterative CORDIC, one micro-rotation a cycle: vectoring or rotation.
// ---------------------------------------------------------------------------
module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int DW    = 36,
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cord_req_t               req,
    input  logic signed [DW-1:0]    in_x,
    input  logic signed [DW-1:0]    in_y,
    input  logic signed [ANG_W-1:0] in_a,
    output logic signed [DW-1:0]    x_res,
    output logic signed [ANG_W-1:0] z_res,
    output logic                    fold_neg,
    output logic                    done
);

    localparam int SW = $clog2(STEPS);

    cstate_t                 state_reg;
    cstate_t                 state_next;
    cmode_t                  mode_reg;
    logic [SW-1:0]           cnt_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic signed [DW-1:0]    x_reg;
    logic signed [DW-1:0]    y_reg;
    logic signed [ANG_W-1:0] z_reg;

    logic signed [DW-1:0]    x_ld;
    logic signed [DW-1:0]    y_ld;
    logic signed [ANG_W-1:0] z_ld;
    logic                    neg_ld;
    logic signed [DW-1:0]    xs;
    logic signed [DW-1:0]    ys;
    logic signed [ANG_W-1:0] t;
    logic                    s_pos;
    logic                    last;

    assign last = (cnt_reg == SW'(STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  if (req.start) state_next = C_RUN;
            C_RUN:   if (last) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // start values, with quadrant pre-turn or fold by pi
    always_comb
    begin
        x_ld   = in_x;
        y_ld   = in_y;
        z_ld   = '0;
        neg_ld = 1'b0;
        if (req.mode == CM_VECTOR)
        begin
            if (in_x[DW-1])
            begin
                if (!in_y[DW-1])
                begin
                    x_ld = in_y;
                    y_ld = -in_x;
                    z_ld = Q_HALF_PI;
                end
                else
                begin
                    x_ld = -in_y;
                    y_ld = in_x;
                    z_ld = -Q_HALF_PI;
                end
            end
        end
        else
        begin
            x_ld = DW'(signed'({1'b0, INV_GAIN}));
            y_ld = '0;
            z_ld = in_a;
            if (in_a > Q_HALF_PI)
            begin
                z_ld   = in_a - Q_PI;
                neg_ld = 1'b1;
            end
            else if (in_a < -Q_HALF_PI)
            begin
                z_ld   = in_a + Q_PI;
                neg_ld = 1'b1;
            end
        end
    end

    always_comb
    begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        t  = signed'(ANG_W'(atan_entry(5'(cnt_reg))));
        if (mode_reg == CM_ROTATE)
            s_pos = !z_reg[ANG_W-1];
        else
            s_pos = y_reg[DW-1] || (y_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && req.start)
        begin
            x_reg    <= x_ld;
            y_reg    <= y_ld;
            z_reg    <= z_ld;
            neg_reg  <= neg_ld;
            mode_reg <= req.mode;
        end
        else if (state_reg == C_RUN)
        begin
            if (s_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_RUN) && last;
            if (state_reg == C_RUN)
                cnt_reg <= last ? '0 : cnt_reg + SW'(1);
            else
                cnt_reg <= '0;
        end
    end

    assign x_res    = x_reg;
    assign z_res    = z_reg;
    assign fold_neg = neg_reg;
    assign done     = done_reg;

endmodule

/* sv/gtg_back.sv */
// ---------------------------------------------------------------------------
// gtg_back
// Executes queued requests: pose/goal store, tick sequencer, result register.
// ---------------------------------------------------------------------------
module gtg_back
    import gtg_pkg::*;
#(
    parameter int CW    = 32,
    parameter int STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  item_t       q_head,
    input  logic        q_empty,
    output logic        q_pop,
    output cord_req_t   cord_req,
    output logic signed [CW+3:0]    cord_x,
    output logic signed [CW+3:0]    cord_y,
    output logic signed [ANG_W-1:0] cord_a,
    input  logic signed [CW+3:0]    cord_xres,
    input  logic signed [ANG_W-1:0] cord_zres,
    input  logic        cord_neg,
    input  logic        cord_done,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    localparam int DW   = CW + 4;
    localparam int LW   = (DW > CFG_W) ? DW : CFG_W;
    localparam int P1W  = CFG_W + DW - 16;
    localparam int SXW  = (P1W + 1 > 49) ? P1W + 1 : 49;
    localparam int APW  = CFG_W + ANG_W;

    bstate_t                 state_reg;
    bstate_t                 state_next;
    phase_t                  phase_reg;
    logic                    pose_known_reg;
    logic                    goal_known_reg;
    logic signed [CW-1:0]    cx_reg;
    logic signed [CW-1:0]    cy_reg;
    logic signed [HDG_W-1:0] ch_reg;
    logic signed [CW-1:0]    tx_reg;
    logic signed [CW-1:0]    ty_reg;
    logic signed [HDG_W-1:0] th_reg;
    logic signed [ANG_W-1:0] err_reg;
    logic signed [ANG_W-1:0] aerr_reg;
    logic [DW-1:0]           mhi_reg;
    logic [DW-1:0]           dist_reg;
    logic signed [17:0]      cos_reg;
    logic [P1W-1:0]          p1_reg;
    logic [46:0]             p2_reg;
    logic [47:0]             p_reg;
    logic [40:0]             qlo_reg;
    logic [40:0]             qhi_reg;
    logic [APW-1:0]          angp_reg;
    logic signed [31:0]      lin_reg;
    logic signed [31:0]      ang_reg;
    logic                    reached_reg;
    logic                    out_valid_reg;
    logic [71:0]             out_data_reg;

    logic signed [CW-1:0]    hx;
    logic signed [CW-1:0]    hy;
    logic                    tick_ok;
    logic                    out_free;
    logic [DW-1:0]           ux;
    logic [31:0]             lo_prod;
    logic signed [ANG_W-1:0] ye;
    logic [ANG_W-2:0]        err_abs;
    logic [ANG_W-2:0]        ye_abs;
    logic [ANG_W-2:0]        aerr_abs;
    logic [16:0]             cos_abs;
    logic                    near;
    bstate_t                 dec_state;
    phase_t                  dec_phase;
    logic                    dec_reached;
    logic signed [ANG_W-1:0] dec_aerr;
    logic signed [DW-1:0]    cx_clamp;
    logic signed [17:0]      cos_val;
    logic [SXW-1:0]          lin_sum;
    logic [65:0]             lin_t;
    logic [CFG_W-1:0]        lin_mag;
    logic [CFG_W-1:0]        ang_mag;

    // coordinate fields as seen at COORD_WIDTH
    generate
        if (CW <= POS_W)
        begin : g_narrow
            assign hx = $signed(q_head.x[CW-1:0]);
            assign hy = $signed(q_head.y[CW-1:0]);
        end
        else
        begin : g_wide
            assign hx = $signed({{(CW-POS_W){1'b0}}, q_head.x});
            assign hy = $signed({{(CW-POS_W){1'b0}}, q_head.y});
        end
    endgenerate

    assign tick_ok  = pose_known_reg && goal_known_reg &&
                      (phase_reg == PH_ROTATE || phase_reg == PH_MOVE ||
                       phase_reg == PH_FINAL);
    assign out_free = !out_valid_reg || m_tready;

    // vector (dy, -dx) for the bearing, angle error for the cosine
    assign cord_x = DW'(ty_reg) - DW'(cy_reg);
    assign cord_y = DW'(cx_reg) - DW'(tx_reg);
    assign cord_a = err_reg;

    always_comb
    begin
        ux       = cord_xres[DW-1] ? '0 : cord_xres;
        lo_prod  = 32'(ux[15:0]) * 32'(INV_GAIN);
        ye       = wrap_angle(ANG_W'(th_reg) - ANG_W'(ch_reg));
        err_abs  = err_reg[ANG_W-1] ? (ANG_W-1)'(-err_reg) : err_reg[ANG_W-2:0];
        ye_abs   = ye[ANG_W-1] ? (ANG_W-1)'(-ye) : ye[ANG_W-2:0];
        aerr_abs = aerr_reg[ANG_W-1] ? (ANG_W-1)'(-aerr_reg) : aerr_reg[ANG_W-2:0];
        cos_abs  = cos_reg[17] ? 17'(-cos_reg) : cos_reg[16:0];
        near     = LW'(dist_reg) < LW'(cfg.dist_tol);
    end

    // cosine: clamp to +-1.0 then undo the fold
    always_comb
    begin
        cx_clamp = cord_xres;
        if (cord_xres > DW'(65536))
            cx_clamp = DW'(65536);
        else if (cord_xres < -DW'(65536))
            cx_clamp = -DW'(65536);
        cos_val = cord_neg ? -18'(cx_clamp) : 18'(cx_clamp);
    end

    // phase decisions on a tick
    always_comb
    begin
        dec_state   = B_EMIT;
        dec_phase   = phase_reg;
        dec_reached = 1'b0;
        dec_aerr    = err_reg;
        unique case (phase_reg)
            PH_ROTATE:
            begin
                if (near)
                begin
                    dec_phase = PH_FINAL;
                    dec_state = B_IDLE;
                end
                else if (CFG_W'(err_abs) > cfg.yaw_tol)
                    dec_state = B_ANG_MUL;
                else
                    dec_phase = PH_MOVE;
            end
            PH_MOVE:
            begin
                if (near)
                    dec_phase = PH_FINAL;
                else if (CFG_W'(err_abs) > cfg.realign)
                    dec_phase = PH_ROTATE;
                else
                    dec_state = B_COS;
            end
            PH_FINAL:
            begin
                if (CFG_W'(ye_abs) > cfg.yaw_tol)
                begin
                    dec_aerr  = ye;
                    dec_state = B_ANG_MUL;
                end
                else
                begin
                    dec_phase   = PH_DONE;
                    dec_reached = 1'b1;
                end
            end
            default:
                dec_state = B_IDLE;
        endcase
    end

    // speed magnitudes, saturated products and clamps
    always_comb
    begin
        lin_sum = SXW'(p1_reg) + SXW'(p2_reg[46:16]);
        lin_t   = 66'({qhi_reg, 24'b0}) + 66'(qlo_reg);
        if (lin_t[65:16] > 50'(cfg.max_lin))
            lin_mag = cfg.max_lin;
        else
            lin_mag = lin_t[16+CFG_W-1:16];
        if (angp_reg[APW-1:16] > (APW-16)'(cfg.max_ang))
            ang_mag = cfg.max_ang;
        else
            ang_mag = angp_reg[16+CFG_W-1:16];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!q_empty && q_head.op == OP_TICK && tick_ok)
                    state_next = B_PREP;
            B_PREP:      state_next = B_VEC;
            B_VEC:       if (cord_done) state_next = B_MAG_HI;
            B_MAG_HI:    state_next = B_MAG_LO;
            B_MAG_LO:    state_next = B_DECIDE;
            B_DECIDE:    state_next = dec_state;
            B_COS:       if (cord_done) state_next = B_LIN_P1;
            B_LIN_P1:    state_next = B_LIN_P2;
            B_LIN_P2:    state_next = B_LIN_SUM;
            B_LIN_SUM:   state_next = B_LIN_QLO;
            B_LIN_QLO:   state_next = B_LIN_QHI;
            B_LIN_QHI:   state_next = B_LIN_CLAMP;
            B_LIN_CLAMP: state_next = B_ANG_MUL;
            B_ANG_MUL:   state_next = B_ANG_CLAMP;
            B_ANG_CLAMP: state_next = B_EMIT;
            B_EMIT:      if (out_free) state_next = B_IDLE;
            default:     state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop          = (state_reg == B_IDLE) && !q_empty;
        cord_req.start = (state_reg == B_PREP) ||
                         ((state_reg == B_DECIDE) && (dec_state == B_COS));
        cord_req.mode  = (state_reg == B_PREP) ? CM_VECTOR : CM_ROTATE;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && !q_empty)
        begin
            if (q_head.op == OP_POSE)
            begin
                cx_reg <= hx;
                cy_reg <= hy;
                ch_reg <= $signed(q_head.hdg);
            end
            else if (q_head.op == OP_GOAL)
            begin
                tx_reg <= hx;
                ty_reg <= hy;
                th_reg <= $signed(q_head.hdg);
            end
        end
        if (state_reg == B_PREP)
        begin
            lin_reg     <= '0;
            ang_reg     <= '0;
            reached_reg <= 1'b0;
        end
        if (state_reg == B_VEC && cord_done)
            err_reg <= wrap_angle(cord_zres - ANG_W'(ch_reg));
        if (state_reg == B_MAG_HI)
            mhi_reg <= DW'(ux[DW-1:16]) * DW'(INV_GAIN);
        if (state_reg == B_MAG_LO)
            dist_reg <= mhi_reg + DW'(lo_prod[31:16]);
        if (state_reg == B_DECIDE)
        begin
            aerr_reg    <= dec_aerr;
            reached_reg <= dec_reached;
        end
        if (state_reg == B_COS && cord_done)
            cos_reg <= cos_val;
        if (state_reg == B_LIN_P1)
            p1_reg <= P1W'(cfg.lin_gain) * P1W'(dist_reg[DW-1:16]);
        if (state_reg == B_LIN_P2)
            p2_reg <= 47'(cfg.lin_gain) * 47'(dist_reg[15:0]);
        if (state_reg == B_LIN_SUM)
            p_reg <= (lin_sum > (SXW'(1) << 47)) ? 48'h8000_0000_0000 : lin_sum[47:0];
        if (state_reg == B_LIN_QLO)
            qlo_reg <= 41'(p_reg[23:0]) * 41'(cos_abs);
        if (state_reg == B_LIN_QHI)
            qhi_reg <= 41'(p_reg[47:24]) * 41'(cos_abs);
        if (state_reg == B_LIN_CLAMP)
            lin_reg <= cos_reg[17] ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});
        if (state_reg == B_ANG_MUL)
            angp_reg <= APW'(cfg.ang_gain) * APW'(aerr_abs);
        if (state_reg == B_ANG_CLAMP)
            ang_reg <= aerr_reg[ANG_W-1] ? -$signed({1'b0, ang_mag})
                                          : $signed({1'b0, ang_mag});
        if (state_reg == B_EMIT && out_free)
            out_data_reg <= {4'b0, phase_reg, reached_reg, ang_reg, lin_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            phase_reg      <= PH_IDLE;
            pose_known_reg <= 1'b0;
            goal_known_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && !q_empty)
            begin
                if (q_head.op == OP_POSE)
                    pose_known_reg <= 1'b1;
                else if (q_head.op == OP_GOAL)
                begin
                    goal_known_reg <= 1'b1;
                    phase_reg      <= PH_ROTATE;
                end
            end
            if (state_reg == B_DECIDE)
                phase_reg <= dec_phase;
            if (state_reg == B_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* sv/go_to_goal_pose_controller.sv */
// Pose and goal requests are absorbed by the back end straight from the queue head.
// A control tick runs the shared CORDIC unit once for bearing/distance and,
// in the move phase, once more for the cosine of the heading error.
// Throughput: one request in flight in the back end, two queued in front.
// Reset (rst_n, async, active low) clears phase, known flags, queue and output.
`include "go_to_goal_pose_controller_defines.svh"
// ---------------------------------------------------------------------------
// go_to_goal_pose_controller
// Proportional go-to-goal controller: pose/goal/tick in, speed commands out.
// ---------------------------------------------------------------------------
module go_to_goal_pose_controller
    import gtg_pkg::*;
#(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,    // pos_x[31:0], pos_y[63:32], heading[82:64], zero pad
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // linear_speed[31:0], angular_speed[63:32],
                                    // reached[64], phase_now[67:65], zero pad
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [30:0] cfg_wdata
);

    localparam int DW = COORD_WIDTH + 4;

    cfg_t                    cfg_reg;
    item_t                   push_item;
    item_t                   q_head;
    logic                    push;
    logic                    q_pop;
    logic                    q_empty;
    logic                    q_full;
    cord_req_t               cord_req;
    logic signed [DW-1:0]    cord_x;
    logic signed [DW-1:0]    cord_y;
    logic signed [ANG_W-1:0] cord_a;
    logic signed [DW-1:0]    cord_xres;
    logic signed [ANG_W-1:0] cord_zres;
    logic                    cord_neg;
    logic                    cord_done;
    logic                    reached_bit;
    logic [2:0]              phase_now;
    logic [31:0]             linear_speed;
    logic [31:0]             angular_speed;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_lin  <= 31'd19661;
            cfg_reg.max_ang  <= 31'd65536;
            cfg_reg.lin_gain <= 31'd39322;
            cfg_reg.ang_gain <= 31'd117965;
            cfg_reg.dist_tol <= 31'd1966;
            cfg_reg.yaw_tol  <= 31'd3277;
            cfg_reg.realign  <= 31'd26214;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_LIN:  cfg_reg.max_lin  <= cfg_wdata;
                REG_MAX_ANG:  cfg_reg.max_ang  <= cfg_wdata;
                REG_LIN_GAIN: cfg_reg.lin_gain <= cfg_wdata;
                REG_ANG_GAIN: cfg_reg.ang_gain <= cfg_wdata;
                REG_DIST_TOL: cfg_reg.dist_tol <= cfg_wdata;
                REG_YAW_TOL:  cfg_reg.yaw_tol  <= cfg_wdata;
                REG_REALIGN:  cfg_reg.realign  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // front: accept and classify requests
    gtg_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // short queue so front and back stall independently
    gtg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // shared CORDIC: bearing/magnitude, then cosine of the heading error
    gtg_cordic #(
        .DW    (DW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (cord_req),
        .in_x     (cord_x),
        .in_y     (cord_y),
        .in_a     (cord_a),
        .x_res    (cord_xres),
        .z_res    (cord_zres),
        .fold_neg (cord_neg),
        .done     (cord_done)
    );

    // back: state, phase machine, speed arithmetic, output register
    gtg_back #(
        .CW    (COORD_WIDTH),
        .STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .cord_req  (cord_req),
        .cord_x    (cord_x),
        .cord_y    (cord_y),
        .cord_a    (cord_a),
        .cord_xres (cord_xres),
        .cord_zres (cord_zres),
        .cord_neg  (cord_neg),
        .cord_done (cord_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign linear_speed  = m_tdata[31:0];
    assign angular_speed = m_tdata[63:32];
    assign reached_bit   = m_tdata[64];
    assign phase_now     = m_tdata[67:65];

    // goal reached only on the tick that enters done, with both speeds zero
    `GTG_ASSERT_IMP(a_reached_done, m_tvalid && reached_bit, phase_now == PH_DONE)
    `GTG_ASSERT_IMP(a_reached_still, m_tvalid && reached_bit,
                    linear_speed == 32'd0 && angular_speed == 32'd0)
    // any other result leaves an active phase
    `GTG_ASSERT_IMP(a_active_phase, m_tvalid && !reached_bit,
                    phase_now == PH_ROTATE || phase_now == PH_MOVE || phase_now == PH_FINAL)
    // CORDIC never reports done straight after a start
    `GTG_ASSERT_NEXT(a_cordic_run, cord_req.start, !cord_done)

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the go-to-goal pose controller.
// Pose, goal and tick requests go in over the input stream. A scoreboard class
// works out each tick's speed command in Q16.16 (CORDIC bearing, distance, cos,
// phase machine) and compares the output stream field by field.
// ----------------------------------------------------------------------------
module testbench;
    import gtg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PI_Q      = 205887;
    localparam longint HALF_PI_Q = 102944;
    localparam longint TWO_PI_Q  = 411774;
    localparam longint RECIP_K   = 39797;
    localparam longint unsigned SAT_47 = 64'd1 << 47;
    localparam bit [30:0] REG_MAX = 31'h7FFF_FFFF;

    // one expected speed command
    typedef struct packed {
        logic [31:0] lin;
        logic [31:0] ang;
        logic        reached;
        logic [2:0]  ph;
    } speed_cmd_t;

    // ------------------------------------------------------------------
    // Scoreboard: controller state, its prediction and the pending commands
    // ------------------------------------------------------------------
    class gtg_scoreboard;
        bit [30:0]  regs [7];
        phase_t     phase;
        bit         pose_known, goal_known;
        longint     cur_x, cur_y, cur_h, tgt_x, tgt_y, tgt_h;
        speed_cmd_t pending [$];
        int         mismatches;
        longint     atan_lut [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                      512, 256, 128, 64, 32, 16, 8, 4, 2};

        function new();
            regs = '{19661, 65536, 39322, 117965, 1966, 3277, 26214};
            phase = PH_IDLE;
            pose_known = 0;
            goal_known = 0;
            {cur_x, cur_y, cur_h, tgt_x, tgt_y, tgt_h} = '0;
            mismatches = 0;
        endfunction

        function longint wrap(longint a);
            while (a > PI_Q) a -= TWO_PI_Q;
            while (a <= -PI_Q) a += TWO_PI_Q;
            return a;
        endfunction

        function longint unsigned mag_of(longint v);
            return v < 0 ? -v : v;
        endfunction

        // vectoring CORDIC: angle of (x, y) plus the gain-corrected length
        function longint vec_angle(longint x, longint y, output longint unsigned len);
            longint z, t, xs, ys;
            longint unsigned ux;
            z = 0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = HALF_PI_Q;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -HALF_PI_Q;
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x += ys; y -= xs; z += atan_lut[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= atan_lut[i];
                end
            end
            ux = x < 0 ? 0 : x;
            len = (ux >> 16) * RECIP_K + (((ux & 64'hFFFF) * RECIP_K) >> 16);
            return z;
        endfunction

        function longint cosine(longint a);
            longint x, y, xs, ys;
            bit flip;
            x = RECIP_K;
            y = 0;
            flip = 0;
            if (a > HALF_PI_Q)
            begin
                a -= PI_Q; flip = 1;
            end
            else if (a < -HALF_PI_Q)
            begin
                a += PI_Q; flip = 1;
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (a >= 0)
                begin
                    x -= ys; y += xs; a -= atan_lut[i];
                end
                else
                begin
                    x += ys; y -= xs; a += atan_lut[i];
                end
            end
            if (x > 65536) x = 65536;
            if (x < -65536) x = -65536;
            return flip ? -x : x;
        endfunction

        function longint clamp(longint unsigned m, bit neg, longint unsigned lim);
            if (m > lim) m = lim;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint turn_rate(longint err);
            return clamp((longint'(regs[REG_ANG_GAIN]) * mag_of(err)) >> 16, err < 0,
                         regs[REG_MAX_ANG]);
        endfunction

        function longint drive_speed(longint unsigned dist_q, longint err);
            longint unsigned g, dh, dl, p;
            longint c;
            g = regs[REG_LIN_GAIN];
            dh = dist_q >> 16;
            dl = dist_q & 64'hFFFF;
            c = cosine(err);
            if (dh != 0 && g > SAT_47 / dh) p = SAT_47;
            else p = g * dh + ((g * dl) >> 16);
            if (p > SAT_47) p = SAT_47;
            return clamp((p * mag_of(c)) >> 16, c < 0, regs[REG_MAX_LIN]);
        endfunction

        // an accepted request: update state, queue the command it causes
        function void note_request(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                                   logic [18:0] hd);
            longint lin, ang, err, ye;
            longint unsigned dist_q;
            bit reached;
            speed_cmd_t r;
            lin = 0;
            ang = 0;
            reached = 0;
            if (cmd == CMD_POSE)
            begin
                cur_x = longint'(signed'(px));
                cur_y = longint'(signed'(py));
                cur_h = longint'(signed'(hd));
                pose_known = 1;
                return;
            end
            if (cmd == CMD_GOAL)
            begin
                tgt_x = longint'(signed'(px));
                tgt_y = longint'(signed'(py));
                tgt_h = longint'(signed'(hd));
                goal_known = 1;
                phase = PH_ROTATE;
                return;
            end
            if (cmd != CMD_TICK || !pose_known || !goal_known) return;
            if (!(phase inside {PH_ROTATE, PH_MOVE, PH_FINAL})) return;
            err = wrap(vec_angle(tgt_y - cur_y, cur_x - tgt_x, dist_q) - cur_h);
            case (phase)
                PH_ROTATE:
                begin
                    if (dist_q < regs[REG_DIST_TOL])
                    begin
                        phase = PH_FINAL;   // position already reached: silent
                        return;
                    end
                    if (mag_of(err) > regs[REG_YAW_TOL]) ang = turn_rate(err);
                    else phase = PH_MOVE;
                end
                PH_MOVE:
                begin
                    if (dist_q < regs[REG_DIST_TOL]) phase = PH_FINAL;
                    else if (mag_of(err) > regs[REG_REALIGN]) phase = PH_ROTATE;
                    else
                    begin
                        lin = drive_speed(dist_q, err);
                        ang = turn_rate(err);
                    end
                end
                default:
                begin
                    ye = wrap(tgt_h - cur_h);
                    if (mag_of(ye) > regs[REG_YAW_TOL]) ang = turn_rate(ye);
                    else
                    begin
                        phase = PH_DONE;
                        reached = 1;
                    end
                end
            endcase
            r.lin = lin[31:0];
            r.ang = ang[31:0];
            r.reached = reached;
            r.ph = phase;
            pending.push_back(r);
        endfunction

        function void check_result(logic [71:0] d);
            speed_cmd_t e, a;
            a = {d[31:0], d[63:32], d[64], d[67:65]};
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected command lin=%0d ang=%0d reached=%0b phase=%0d",
                             $realtime, signed'(a.lin), signed'(a.ang), a.reached, a.ph);
                return;
            end
            e = pending.pop_front();
            if (a !== e || d[71:68] !== 4'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: command mismatch exp lin=%0d ang=%0d reached=%0b phase=%0d",
                             $realtime, signed'(e.lin), signed'(e.ang), e.reached, e.ph,
                             " got lin=%0d ang=%0d reached=%0b phase=%0d pad=%h",
                             signed'(a.lin), signed'(a.ang), a.reached, a.ph, d[71:68]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;     // pos_x[31:0], pos_y[63:32], heading[82:64], zero pad
    logic [1:0]  s_tuser;     // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;     // linear_speed[31:0], angular_speed[63:32],
                              // reached[64], phase_now[67:65], zero pad
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [30:0] cfg_wdata;

    gtg_scoreboard sb = new();

    int gap_pct;       // chance in 100 of the sender idling after a request
    int stall_pct;     // chance in 100 of the receiver stalling on each clock
    int hold_off;      // cycles the receiver still holds m_tready low

    go_to_goal_pose_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: check on each accepted command, then pick next cycle's tready
    initial
    begin
        m_tready = 0;
        hold_off = 0;
        stall_pct = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one request; valid stays high into the next one unless the sender idles
    task automatic send(logic [1:0] cmd, logic [31:0] px, logic [31:0] py, logic [18:0] hd);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, hd, py, px};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(cmd, px, py, hd);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pending command, then let a silent tick or two drain
    task automatic drain();
        pause_sender();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_regs(bit [30:0] v [7]);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= v[i];
            sb.regs[i] = v[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // heading that faces the current goal from (px, py), plus some noise
    function automatic logic [18:0] facing(logic [31:0] px, logic [31:0] py, int noise);
        longint unsigned len;
        longint b;
        b = sb.vec_angle(sb.tgt_y - longint'(signed'(py)),
                         longint'(signed'(px)) - sb.tgt_x, len);
        return 19'(sb.wrap(b + noise));
    endfunction

    function automatic logic [31:0] near(longint c, int span);
        return 32'(c + $urandom_range(2 * span) - span);
    endfunction

    // random request, mostly goal/pose/tick sequences that walk the phases
    task automatic random_request();
        int k, r;
        logic [31:0] px, py;
        logic [18:0] hd;
        k = $urandom_range(99);
        r = $urandom_range(9);
        if (k < 8)
        begin
            if (r < 2)
            begin
                px = $urandom();
                py = $urandom();
            end
            else
            begin
                px = near(0, 1 << 22);
                py = near(0, 1 << 22);
            end
            send(CMD_GOAL, px, py, 19'(signed'($urandom_range(2 * PI_Q)) - PI_Q));
        end
        else if (k < 48)
        begin
            if (r < 1)
            begin
                px = $urandom();
                py = $urandom();
            end
            else if (r < 4)
            begin
                px = near(sb.tgt_x, 1500);   // mostly inside the default tolerance
                py = near(sb.tgt_y, 1500);
            end
            else
            begin
                px = near(sb.tgt_x, 1 << 20);
                py = near(sb.tgt_y, 1 << 20);
            end
            r = $urandom_range(9);
            if (r < 4)      hd = facing(px, py, $urandom_range(60000) - 30000);
            else if (r < 6) hd = 19'(sb.wrap(sb.tgt_h + $urandom_range(8000) - 4000));
            else            hd = 19'($urandom_range(2 * PI_Q) - PI_Q);
            send(CMD_POSE, px, py, hd);
        end
        else if (k < 95)
            send(CMD_TICK, $urandom(), $urandom(), 19'($urandom()));
        else
            send(CMD_RESERVED, $urandom(), $urandom(), 19'($urandom()));
    endtask

    initial
    begin
        bit [30:0] regset [7];
        int mode;
        rst_n     = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = CMD_POSE;
        cfg_we    = 0;
        cfg_addr  = REG_MAX_LIN;
        cfg_wdata = '0;
        gap_pct   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: not ready, reserved code, extremes, each phase and goal reached
        send(CMD_TICK, 0, 0, 0);                        // no pose, no goal yet
        send(CMD_POSE, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0);                        // still no goal
        send(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 19'h7FFFF);
        send(CMD_GOAL, 32'h7FFF_FFFF, 32'h8000_0000, 19'(PI_Q));
        send(CMD_POSE, 32'h8000_0000, 32'h7FFF_FFFF, 19'(-PI_Q));
        send(CMD_TICK, 0, 0, 0);                        // rotate, far and turned
        send(CMD_GOAL, 0, 0, 19'(-PI_Q));
        send(CMD_POSE, 100, -100, 19'(PI_Q));
        send(CMD_TICK, 0, 0, 0);                        // close enough: silent to final
        send(CMD_TICK, 0, 0, 0);                        // wrap of 2*pi: heading already matches, goal reached
        send(CMD_POSE, 100, -100, 19'(-PI_Q));
        send(CMD_TICK, 0, 0, 0);                        // done: silent
        send(CMD_TICK, 0, 0, 0);                        // done: silent
        send(CMD_GOAL, 32'h0004_0000, 32'hFFFC_0000, 19'(HALF_PI_Q));
        send(CMD_POSE, 0, 0, facing(0, 0, 0));
        send(CMD_TICK, 0, 0, 0);                        // aligned: into move
        send(CMD_TICK, 0, 0, 0);                        // move, both speeds
        send(CMD_POSE, 0, 0, facing(0, 0, 60000));
        send(CMD_TICK, 0, 0, 0);                        // too far off: back to rotate
        send(CMD_POSE, 32'h0004_0100, 32'hFFFC_0000, 0);
        send(CMD_TICK, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: regset = '{19661, 65536, 39322, 117965, 1966, 3277, 26214};
                1: regset = '{REG_MAX, REG_MAX, REG_MAX, REG_MAX, 1966, 3277, 26214};
                2: regset = '{0, 0, 0, 0, 0, 0, 0};
                3: regset = '{REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX,
                              REG_MAX};
                default:
                    foreach (regset[i])
                        regset[i] = ($urandom_range(3) == 0) ? 31'($urandom())
                                                             : 31'($urandom_range(200000));
            endcase
            write_regs(regset);
            mode = ph % 4;
            gap_pct   = (mode == 1) ? 61 : (mode == 3) ? 14 : 0;
            stall_pct = (mode == 2) ? 61 : (mode == 3) ? 14 : 0;
            for (int n = 0; n < 130; n++)
            begin
                // long receiver hold-off while requests keep coming: input backs up
                if (ph == 1 && n == 40)
                    hold_off = 600;
                random_request();
            end
            drain();
        end

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/gtg_pkg.sv
sv/gtg_front.sv
sv/gtg_queue.sv
sv/gtg_cordic.sv
sv/gtg_back.sv
sv/go_to_goal_pose_controller.sv
dv/testbench.sv
